// File: rtl/fma64_pkg.sv
`default_nettype none
package fma64_pkg;

	localparam int FRAC_W    = 52;
	localparam int MAN_W     = 53;
	localparam int EXP_W     = 11;
	localparam int WORD_W    = 64;
	// Sum window: addend above the product, two spare bits and a sticky bit below it.
	// The spare bits keep the guard clear of the sticky bit when a subnormal factor
	// leaves the product short.
	localparam int WIN_W     = 166;
	localparam int CHUNK_W   = 16;
	localparam int N_CHUNK   = (WIN_W + CHUNK_W - 1) / CHUNK_W;
	localparam int PAD_W     = N_CHUNK * CHUNK_W - WIN_W;
	localparam int CHUNK_LZ_W = $clog2(CHUNK_W);
	localparam int CHUNK_SEL_W = $clog2(N_CHUNK);

	localparam logic [EXP_W-1:0]  EXP_ALL_ONES = 11'h7ff;
	localparam logic [WORD_W-1:0] QNAN_BITS    = 64'h7ff8_0000_0000_0000;
	localparam logic [WORD_W-1:0] INF_BITS     = 64'h7ff0_0000_0000_0000;

	typedef struct packed {
		logic                  nonzero;
		logic [CHUNK_LZ_W-1:0] lz;
	} chunk_cnt_t;

endpackage
`default_nettype wire

// File: rtl/fused_multiply_add_binary64_core.sv
`default_nettype none
// Channel   Direction  Payload
// s_*       in         tdata[191:0] = {addend, mult_b, mult_a}
// m_*       out        tdata[63:0]  = sum_bits
//
// Seven pipeline stages: one request per cycle while the output is not stalled.
// The 53x53 significand product is split into four partial products in stage 1.
// Leading-zero search takes two stages, normalize shift one, rounding one.
// Valid bits travel with each stage; a stage holds only when the next one is full
// and stalled, so bubbles are squeezed out and nothing is lost or repeated.
// Reset clears the valid bits only.
module fused_multiply_add_binary64_core (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [191:0] s_tdata,   // mult_a[63:0], mult_b[127:64], addend[191:128]
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [63:0]  m_tdata    // sum_bits[63:0]
);
	import fma64_pkg::*;

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7;
	logic en1, en2, en3, en4, en5, en6, en7;

	assign en7 = m_tready | ~v_s7;
	assign en6 = en7 | ~v_s6;
	assign en5 = en6 | ~v_s5;
	assign en4 = en5 | ~v_s4;
	assign en3 = en4 | ~v_s3;
	assign en2 = en3 | ~v_s2;
	assign en1 = en2 | ~v_s1;
	assign s_tready = en1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0; v_s2 <= 1'b0; v_s3 <= 1'b0; v_s4 <= 1'b0;
			v_s5 <= 1'b0; v_s6 <= 1'b0; v_s7 <= 1'b0;
		end else begin
			if (en1) v_s1 <= s_tvalid;
			if (en2) v_s2 <= v_s1;
			if (en3) v_s3 <= v_s2;
			if (en4) v_s4 <= v_s3;
			if (en5) v_s5 <= v_s4;
			if (en6) v_s6 <= v_s5;
			if (en7) v_s7 <= v_s6;
		end
	end

	// Stage 1: unpack, special operands, partial products, exponent alignment.
	logic [WORD_W-1:0] a_in, b_in, c_in;
	logic              sa, sb, sc, sp;
	logic [EXP_W-1:0]  ea, eb, ec, ea1, eb1, ec1;
	logic [FRAC_W-1:0] fa, fb, fc;
	logic              nan_a, nan_b, nan_c, inf_a, inf_b, inf_c, zero_a, zero_b;
	logic [MAN_W-1:0]  ma, mb, mc;
	logic              byp;
	logic [WORD_W-1:0] byp_val;
	logic [26:0]       ah, bh;
	logic [25:0]       al, bl;
	logic [53:0]       pp_hh;
	logic [52:0]       pp_hl, pp_lh;
	logic [51:0]       pp_ll;
	logic signed [12:0] pe, ce, amt, base;
	logic              clamp;
	logic [7:0]        ash;

	assign a_in = s_tdata[63:0];
	assign b_in = s_tdata[127:64];
	assign c_in = s_tdata[191:128];
	assign {sa, ea, fa} = a_in;
	assign {sb, eb, fb} = b_in;
	assign {sc, ec, fc} = c_in;
	assign sp = sa ^ sb;

	assign nan_a  = (ea == EXP_ALL_ONES) && (fa != '0);
	assign nan_b  = (eb == EXP_ALL_ONES) && (fb != '0);
	assign nan_c  = (ec == EXP_ALL_ONES) && (fc != '0);
	assign inf_a  = (ea == EXP_ALL_ONES) && (fa == '0);
	assign inf_b  = (eb == EXP_ALL_ONES) && (fb == '0);
	assign inf_c  = (ec == EXP_ALL_ONES) && (fc == '0);
	assign zero_a = (ea == '0) && (fa == '0);
	assign zero_b = (eb == '0) && (fb == '0);

	assign ma = {ea != '0, fa};
	assign mb = {eb != '0, fb};
	assign mc = {ec != '0, fc};

	always_comb begin
		byp = 1'b1;
		byp_val = QNAN_BITS;
		priority if (nan_a || nan_b || nan_c) begin
			byp_val = QNAN_BITS;
		end else if ((inf_a && zero_b) || (inf_b && zero_a)) begin
			byp_val = QNAN_BITS;
		end else if (inf_a || inf_b) begin
			byp_val = (inf_c && (sc != sp)) ? QNAN_BITS : {sp, INF_BITS[62:0]};
		end else if (inf_c) begin
			byp_val = c_in;
		end else if (zero_a || zero_b) begin
			byp_val = (mc != '0) ? c_in : {sp & sc, 63'b0};
		end else begin
			byp = 1'b0;
		end
	end

	assign ah = ma[52:26];
	assign al = ma[25:0];
	assign bh = mb[52:26];
	assign bl = mb[25:0];
	assign pp_hh = ah * bh;
	assign pp_hl = ah * bl;
	assign pp_lh = al * bh;
	assign pp_ll = al * bl;

	assign ea1 = (ea == '0) ? 11'd1 : ea;
	assign eb1 = (eb == '0) ? 11'd1 : eb;
	assign ec1 = (ec == '0) ? 11'd1 : ec;
	assign pe  = $signed({2'b0, ea1}) + $signed({2'b0, eb1}) - 13'sd2150;
	assign ce  = $signed({2'b0, ec1}) - 13'sd1075;
	assign amt = 13'sd109 + pe - ce;
	// When the addend sits far above the product, the product shrinks to a sticky bit.
	assign clamp = amt < 13'sd0;
	assign ash = clamp ? 8'd0 : ((amt > 13'sd165) ? 8'd165 : amt[7:0]);
	assign base = clamp ? (ce + 13'sd1076) : (pe + 13'sd1185);

	logic              byp_s1, sp_s1, sc_s1, clamp_s1;
	logic [WORD_W-1:0] byp_val_s1;
	logic [53:0]       pp_hh_s1;
	logic [52:0]       pp_hl_s1, pp_lh_s1;
	logic [51:0]       pp_ll_s1;
	logic [MAN_W-1:0]  mc_s1;
	logic [7:0]        ash_s1;
	logic signed [12:0] base_s1;

	always_ff @(posedge clk) begin
		if (en1) begin
			byp_s1 <= byp; byp_val_s1 <= byp_val; sp_s1 <= sp; sc_s1 <= sc;
			pp_hh_s1 <= pp_hh; pp_hl_s1 <= pp_hl; pp_lh_s1 <= pp_lh; pp_ll_s1 <= pp_ll;
			mc_s1 <= mc; ash_s1 <= ash; clamp_s1 <= clamp; base_s1 <= base;
		end
	end

	// Stage 2: sum the partial products, align the addend with a sticky bit.
	logic [105:0] prod;
	logic [164:0] a_full, a_shr;
	logic         a_lost;

	assign prod = (106'(pp_hh_s1) << 52)
		+ ((106'(pp_hl_s1) + 106'(pp_lh_s1)) << 26)
		+ 106'(pp_ll_s1);
	assign a_full = {mc_s1, 112'b0};
	assign a_shr  = a_full >> ash_s1;
	assign a_lost = |(a_full << (8'd165 - ash_s1));

	logic              byp_s2, sp_s2, sc_s2, clamp_s2;
	logic [WORD_W-1:0] byp_val_s2;
	logic [105:0]      prod_s2;
	logic [164:0]      a_ext_s2;
	logic signed [12:0] base_s2;

	always_ff @(posedge clk) begin
		if (en2) begin
			byp_s2 <= byp_s1; byp_val_s2 <= byp_val_s1; sp_s2 <= sp_s1; sc_s2 <= sc_s1;
			clamp_s2 <= clamp_s1; base_s2 <= base_s1; prod_s2 <= prod;
			a_ext_s2 <= a_shr | {164'b0, a_lost};
		end
	end

	// Stage 3: add or subtract; the magnitude is taken from whichever difference is positive.
	logic [WIN_W-1:0] p_ext, a_ext, sum_add, diff_ap, mag;
	logic [WIN_W:0]   diff_pa;
	logic             eff_sub, res_sign;

	assign p_ext   = clamp_s2 ? WIN_W'(1) : {57'b0, prod_s2, 3'b0};
	assign a_ext   = {1'b0, a_ext_s2};
	assign sum_add = p_ext + a_ext;
	assign diff_pa = {1'b0, p_ext} - {1'b0, a_ext};
	assign diff_ap = a_ext - p_ext;
	assign eff_sub = sp_s2 ^ sc_s2;
	assign mag = !eff_sub ? sum_add : (diff_pa[WIN_W] ? diff_ap : diff_pa[WIN_W-1:0]);
	assign res_sign = (eff_sub && diff_pa[WIN_W]) ? sc_s2 : sp_s2;

	logic              byp_s3, sign_s3;
	logic [WORD_W-1:0] byp_val_s3;
	logic [WIN_W-1:0]  mag_s3;
	logic signed [12:0] base_s3;

	always_ff @(posedge clk) begin
		if (en3) begin
			byp_s3 <= byp_s2; byp_val_s3 <= byp_val_s2; sign_s3 <= res_sign;
			mag_s3 <= mag; base_s3 <= base_s2;
		end
	end

	// Stage 4: per-chunk leading-zero counts.
	chunk_cnt_t cnt [N_CHUNK];

	fma64_chunk_lzc u_lzc (
		.mag (mag_s3),
		.cnt (cnt)
	);

	logic              byp_s4, sign_s4;
	logic [WORD_W-1:0] byp_val_s4;
	logic [WIN_W-1:0]  mag_s4;
	logic signed [12:0] base_s4;
	chunk_cnt_t        cnt_s4 [N_CHUNK];

	always_ff @(posedge clk) begin
		if (en4) begin
			byp_s4 <= byp_s3; byp_val_s4 <= byp_val_s3; sign_s4 <= sign_s3;
			mag_s4 <= mag_s3; base_s4 <= base_s3; cnt_s4 <= cnt;
		end
	end

	// Stage 5: pick the leading chunk and limit the shift at the subnormal boundary.
	logic [CHUNK_SEL_W-1:0] sel;
	logic [CHUNK_LZ_W-1:0]  loc;
	logic                   any_set;
	logic [8:0]             lz_wide;
	logic [7:0]             lz;
	logic signed [12:0]     bm1;
	logic [7:0]             sh;
	logic [11:0]            exp_m1;

	always_comb begin
		sel = '0;
		loc = '0;
		any_set = 1'b0;
		for (int j = 0; j < N_CHUNK; j++) begin
			if (cnt_s4[j].nonzero) begin
				sel = CHUNK_SEL_W'(j);
				loc = cnt_s4[j].lz;
				any_set = 1'b1;
			end
		end
	end

	assign lz_wide = (9'(N_CHUNK - 1) - 9'(sel)) * 9'(CHUNK_W) + 9'(loc) - 9'(PAD_W);
	assign lz  = lz_wide[7:0];
	assign bm1 = base_s4 - 13'sd1;

	always_comb begin
		if ($signed({5'b0, lz}) <= bm1) begin
			sh = lz;
			exp_m1 = 12'(bm1 - $signed({5'b0, lz}));
		end else begin
			sh = bm1[7:0];
			exp_m1 = '0;
		end
	end

	logic              byp_s5, sign_s5, zero_s5;
	logic [WORD_W-1:0] byp_val_s5;
	logic [WIN_W-1:0]  mag_s5;
	logic [7:0]        sh_s5;
	logic [11:0]       exp_m1_s5;

	always_ff @(posedge clk) begin
		if (en5) begin
			byp_s5 <= byp_s4; byp_val_s5 <= byp_val_s4; sign_s5 <= sign_s4;
			zero_s5 <= ~any_set; mag_s5 <= mag_s4; sh_s5 <= sh; exp_m1_s5 <= exp_m1;
		end
	end

	// Stage 6: normalize.
	logic [WIN_W-1:0] norm;

	assign norm = mag_s5 << sh_s5;

	logic              byp_s6, sign_s6, zero_s6, guard_s6, sticky_s6;
	logic [WORD_W-1:0] byp_val_s6;
	logic [MAN_W-1:0]  keep_s6;
	logic [11:0]       exp_m1_s6;

	always_ff @(posedge clk) begin
		if (en6) begin
			byp_s6 <= byp_s5; byp_val_s6 <= byp_val_s5; sign_s6 <= sign_s5;
			zero_s6 <= zero_s5; exp_m1_s6 <= exp_m1_s5;
			keep_s6 <= norm[165:113]; guard_s6 <= norm[112]; sticky_s6 <= |norm[111:0];
		end
	end

	// Stage 7: round to nearest even; a carry out of the significand bumps the exponent.
	logic              inc;
	logic [MAN_W:0]    q;
	logic [64:0]       packed_val;
	logic              ovf;
	logic [WORD_W-1:0] result;

	assign inc = guard_s6 & (sticky_s6 | keep_s6[0]);
	assign q   = {1'b0, keep_s6} + (MAN_W + 1)'(inc);
	assign packed_val = {1'b0, exp_m1_s6, 52'b0} + 65'(q);
	assign ovf = packed_val[64:52] >= 13'(EXP_ALL_ONES);

	always_comb begin
		priority if (byp_s6) begin
			result = byp_val_s6;
		end else if (zero_s6) begin
			result = '0;
		end else if (ovf) begin
			result = {sign_s6, INF_BITS[62:0]};
		end else begin
			result = {sign_s6, packed_val[62:0]};
		end
	end

	logic [WORD_W-1:0] res_s7;

	always_ff @(posedge clk) begin
		if (en7) begin
			res_s7 <= result;
		end
	end

	assign m_tvalid = v_s7;
	assign m_tdata  = res_s7;

	a_enter: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> v_s1)
		else $error("accepted request did not reach stage 1");

	a_base: assert property (@(posedge clk) disable iff (!arst_n)
		v_s4 && !byp_s4 |-> base_s4 >= 13'sd1)
		else $error("window exponent below subnormal floor");

	a_shift: assert property (@(posedge clk) disable iff (!arst_n)
		v_s5 && !byp_s5 && !zero_s5 |-> sh_s5 <= 8'd165)
		else $error("normalize shift out of range");

	a_norm: assert property (@(posedge clk) disable iff (!arst_n)
		v_s6 && !byp_s6 && !zero_s6 |-> keep_s6[52] || exp_m1_s6 == '0)
		else $error("significand neither normalized nor subnormal");

endmodule
`default_nettype wire

// File: rtl/fma64_chunk_lzc.sv
`default_nettype none
module fma64_chunk_lzc (
	input  logic [fma64_pkg::WIN_W-1:0] mag,
	output fma64_pkg::chunk_cnt_t       cnt [fma64_pkg::N_CHUNK]
);
	import fma64_pkg::*;

	logic [N_CHUNK*CHUNK_W-1:0] padded;
	logic [CHUNK_W-1:0]         seg;

	assign padded = {{PAD_W{1'b0}}, mag};

	// Leading-zero count inside each chunk; the highest set bit wins.
	always_comb begin
		for (int j = 0; j < N_CHUNK; j++) begin
			seg = padded[j*CHUNK_W +: CHUNK_W];
			cnt[j].nonzero = |seg;
			cnt[j].lz = '0;
			for (int i = 0; i < CHUNK_W; i++) begin
				if (seg[i]) begin
					cnt[j].lz = CHUNK_LZ_W'(CHUNK_W - 1 - i);
				end
			end
		end
	end

endmodule
`default_nettype wire

// File: tb/tb_fused_multiply_add_binary64_core.sv
module tb_fused_multiply_add_binary64_core;
	import fma64_pkg::*;

	logic         clk;
	logic         arst_n;
	logic         s_tvalid;
	logic         s_tready;
	logic [191:0] s_tdata;    // mult_a[63:0], mult_b[127:64], addend[191:128]
	logic         m_tvalid;
	logic         m_tready;
	logic [63:0]  m_tdata;    // sum_bits[63:0]

	logic [191:0] pending_reqs[$];
	logic [63:0]  expected_sums[$];
	int           mismatches = 0;
	int           sums_checked = 0;
	int           special_sums = 0;
	int           reqs_accepted = 0;
	int           send_idle = 0;
	int           recv_stall = 0;
	bit           req_fire = 0;
	bit           quiet_tail = 0;
	bit           drain_pause = 0;

	fused_multiply_add_binary64_core dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
	);

	always begin
		clk = 1'b1; #5;
		clk = 1'b0; #5;
	end

	function automatic int top_bit(logic [127:0] x);
		for (int i = 127; i > 0; i--)
			if (x[i]) return i;
		return 0;
	endfunction

	// Right shift that folds every lost bit into bit 0.
	function automatic logic [127:0] shr_sticky(logic [127:0] x, int n);
		logic [127:0] r;
		logic [127:0] lost_mask;
		if (n == 0) return x;
		if (n >= 128) return {127'b0, |x};
		r = x >> n;
		lost_mask = (128'd1 << n) - 128'd1;
		r[0] = r[0] | (|(x & lost_mask));
		return r;
	endfunction

	// Round sign * mag * 2^e to binary64, nearest even; mag is nonzero.
	function automatic logic [63:0] round_to_double(logic sign, logic [127:0] mag, int e);
		int           shift;
		int           qe;
		int           biased;
		logic [127:0] t;
		logic [63:0]  q;
		shift = top_bit(mag) - FRAC_W;
		if (shift < -1074 - e) shift = -1074 - e;
		if (shift < 2) t = mag << (2 - shift);
		else t = shr_sticky(mag, (shift - 2) > 200 ? 200 : shift - 2);
		q = {2'b0, t[63:2]};
		qe = e + shift;
		if (t[1] && (t[0] || q[0])) q = q + 64'd1;
		if (q[53]) begin
			q = q >> 1;
			qe++;
		end
		if (q < (64'd1 << FRAC_W)) return {sign, q[62:0]};
		biased = qe + 1075;
		if (biased >= 2047) return {sign, INF_BITS[62:0]};
		return {sign, biased[10:0], q[51:0]};
	endfunction

	function automatic logic [63:0] fused_sum(logic [63:0] a, logic [63:0] b, logic [63:0] c);
		logic [10:0]  ea, eb, ec;
		logic [51:0]  fa, fb, fc;
		logic         sp, sbig;
		logic [127:0] prod, cmag, big, lesser, r;
		logic [52:0]  ma, mb, mc;
		int           ep, ecx, ebig, esm, sh;
		ea = a[62:52]; eb = b[62:52]; ec = c[62:52];
		fa = a[51:0];  fb = b[51:0];  fc = c[51:0];
		sp = a[63] ^ b[63];
		if ((ea == EXP_ALL_ONES && fa != 0) || (eb == EXP_ALL_ONES && fb != 0) ||
		    (ec == EXP_ALL_ONES && fc != 0))
			return QNAN_BITS;
		if ((ea == EXP_ALL_ONES && b[62:0] == 0) || (eb == EXP_ALL_ONES && a[62:0] == 0))
			return QNAN_BITS;
		if (ea == EXP_ALL_ONES || eb == EXP_ALL_ONES) begin
			if (ec == EXP_ALL_ONES && c[63] != sp) return QNAN_BITS;
			return {sp, INF_BITS[62:0]};
		end
		if (ec == EXP_ALL_ONES) return c;
		ma = {ea != 0, fa};
		mb = {eb != 0, fb};
		mc = {ec != 0, fc};
		if (ma == 0 || mb == 0) begin
			if (mc != 0) return c;
			return {sp & c[63], 63'b0};
		end
		prod = 128'(ma) * 128'(mb);
		ep = (ea != 0 ? int'(ea) : 1) + (eb != 0 ? int'(eb) : 1) - 2150;
		sh = 125 - top_bit(prod);
		prod = prod << sh;
		ep -= sh;
		if (mc == 0) return round_to_double(sp, prod, ep);
		cmag = 128'(mc);
		ecx = (ec != 0 ? int'(ec) : 1) - 1075;
		sh = 125 - top_bit(cmag);
		cmag = cmag << sh;
		ecx -= sh;
		if (ep > ecx || (ep == ecx && prod >= cmag)) begin
			big = prod; ebig = ep; sbig = sp; lesser = cmag; esm = ecx;
		end else begin
			big = cmag; ebig = ecx; sbig = c[63]; lesser = prod; esm = ep;
		end
		sh = ebig - esm;
		lesser = shr_sticky(lesser, sh > 200 ? 200 : sh);
		if (sp == c[63]) begin
			r = big + lesser;
		end else begin
			r = big - lesser;
			if (r == 0) return 64'd0;
		end
		return round_to_double(sbig, r, ebig);
	endfunction

	function automatic logic [63:0] rand_operand();
		logic [63:0] v;
		v = {$urandom, $urandom};
		case ($urandom_range(0, 15))
			0: v[62:0] = 0;
			1: v[62:0] = INF_BITS[62:0];
			2: v[62:52] = EXP_ALL_ONES;
			3: v[62:52] = 0;
			4: v[62:52] = 11'($urandom_range(1, 60));
			5: v[62:52] = 11'($urandom_range(1990, 2046));
			6: v[51:0] = $urandom_range(0, 1) ? '1 : 52'($urandom_range(0, 7));
			default: v[62:52] = 11'($urandom_range(900, 1150));
		endcase
		return v;
	endfunction

	// Addend close to minus the product, so that the sum cancels heavily.
	function automatic logic [63:0] near_negation(logic [63:0] a, logic [63:0] b);
		logic [63:0] c;
		int          e;
		c = {$urandom, $urandom};
		c[63] = ~(a[63] ^ b[63]);
		e = int'(a[62:52]) + int'(b[62:52]) - 1023 + $urandom_range(0, 2) - 1;
		if (e < 0) e = 0;
		if (e > 2046) e = 2046;
		c[62:52] = 11'(e);
		if ($urandom_range(0, 1)) c[51:0] = a[51:0] ^ b[51:0] ^ 52'($urandom_range(0, 3));
		return c;
	endfunction

	task automatic report_mismatch(logic [63:0] got, logic [63:0] want);
		$display("sum_bits mismatch at %0t: got %h, expected %h", $realtime, got, want);
		mismatches++;
	endtask

	task automatic queue_req(logic [63:0] a, logic [63:0] b, logic [63:0] c);
		pending_reqs.push_back({c, b, a});
	endtask

	always @(posedge clk) begin
		req_fire = s_tvalid && s_tready;
		if (m_tvalid && m_tready) begin
			if (expected_sums.size() == 0) begin
				report_mismatch(m_tdata, 64'bx);
			end else begin
				logic [63:0] want;
				want = expected_sums.pop_front();
				if (m_tdata !== want) report_mismatch(m_tdata, want);
				if (want[62:52] == EXP_ALL_ONES) special_sums++;
				sums_checked++;
			end
		end
		if (req_fire) begin
			expected_sums.push_back(fused_sum(s_tdata[63:0], s_tdata[127:64], s_tdata[191:128]));
			reqs_accepted++;
		end
	end

	always @(negedge clk) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else if (!(s_tvalid && !req_fire)) begin
			if (drain_pause && expected_sums.size() == 0) drain_pause = 0;
			if (send_idle > 0) begin
				send_idle--;
				s_tvalid <= 1'b0;
			end else if (drain_pause || pending_reqs.size() == 0) begin
				s_tvalid <= 1'b0;
			end else begin
				s_tvalid <= 1'b1;
				s_tdata <= pending_reqs.pop_front();
				if (!quiet_tail && $urandom_range(0, 11) == 0) send_idle = $urandom_range(1, 19);
			end
		end
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else if (recv_stall > 0) begin
			recv_stall--;
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
			if (!quiet_tail && $urandom_range(0, 11) == 0) recv_stall = $urandom_range(1, 19);
		end
	end

	initial begin
		logic [63:0] a, b, c;
		s_tvalid = 1'b0;
		s_tdata = '0;
		m_tready = 1'b0;
		arst_n = 1'b0;
		// Directed requests: signed zeros, infinities, NaNs, subnormals, extremes.
		queue_req(64'h0, 64'h0, 64'h8000_0000_0000_0000);
		queue_req(64'h8000_0000_0000_0000, 64'h0, 64'h8000_0000_0000_0000);
		queue_req(64'h0, 64'h4000_0000_0000_0000, 64'h3ff0_0000_0000_0000);
		queue_req(64'h7ff0_0000_0000_0000, 64'h0, 64'h3ff0_0000_0000_0000);
		queue_req(64'h7ff0_0000_0000_0000, 64'h3ff0_0000_0000_0000, 64'hfff0_0000_0000_0000);
		queue_req(64'hfff0_0000_0000_0000, 64'h3ff0_0000_0000_0000, 64'hfff0_0000_0000_0000);
		queue_req(64'h3ff0_0000_0000_0000, 64'h3ff0_0000_0000_0000, 64'h7ff0_0000_0000_0000);
		queue_req(64'hfff8_1234_0000_0001, 64'h3ff0_0000_0000_0000, 64'h0);
		queue_req(64'h0, 64'h7ff0_0000_0000_0001, 64'h0);
		queue_req(64'h3ff0_0000_0000_0000, 64'h3ff0_0000_0000_0000, 64'hffff_ffff_ffff_ffff);
		queue_req(64'h3ff0_0000_0000_0000, 64'h3ff0_0000_0000_0000, 64'hbff0_0000_0000_0000);
		queue_req(64'h7fef_ffff_ffff_ffff, 64'h7fef_ffff_ffff_ffff, 64'h0);
		queue_req(64'h7fef_ffff_ffff_ffff, 64'h3ff0_0000_0000_0001, 64'hffef_ffff_ffff_ffff);
		queue_req(64'h0000_0000_0000_0001, 64'h3fe0_0000_0000_0000, 64'h0);
		queue_req(64'h0000_0000_0000_0001, 64'h3ff8_0000_0000_0000, 64'h0);
		queue_req(64'h000f_ffff_ffff_ffff, 64'h3ff0_0000_0000_0001, 64'h8000_0000_0000_0001);
		queue_req(64'h0010_0000_0000_0000, 64'h0010_0000_0000_0000, 64'h0000_0000_0000_0001);
		queue_req(64'h3ff0_0000_0000_0001, 64'h3ff0_0000_0000_0001, 64'hbff0_0000_0000_0002);
		queue_req(64'h3ff0_0000_0000_0000, 64'h3ff0_0000_0000_0000, 64'h3ca0_0000_0000_0000);
		queue_req(64'h3ff0_0000_0000_0000, 64'h3ff0_0000_0000_0001, 64'h3ca0_0000_0000_0000);
		queue_req(64'hffff_ffff_ffff_ffff, 64'hffff_ffff_ffff_ffff, 64'hffff_ffff_ffff_ffff);
		queue_req(64'h8000_0000_0000_0001, 64'h8000_0000_0000_0001, 64'h8000_0000_0000_0000);
		// Subnormal factor with the addend just below the short product.
		queue_req(64'h0000_0000_0000_0001, 64'h7d00_0000_0000_0001, 64'h39c0_0000_0000_0001);
		for (int i = 0; i < 1200; i++) begin
			a = rand_operand();
			b = rand_operand();
			c = ($urandom_range(0, 3) == 0) ? near_negation(a, b) : rand_operand();
			queue_req(a, b, c);
		end
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		wait (pending_reqs.size() < 650);
		drain_pause = 1;
		wait (pending_reqs.size() < 150);
		quiet_tail = 1;
		wait (pending_reqs.size() == 0 && !(s_tvalid && !req_fire));
		@(posedge clk);
		wait (expected_sums.size() == 0);
		repeat (20) @(posedge clk);
		$display("Ran %0d multiply-add requests with signed zeros, infinities, NaNs,",
		         reqs_accepted);
		$display("subnormals and cancellation; %0d sums checked, %0d infinite or NaN.",
		         sums_checked, special_sums);
		if (mismatches == 0 && expected_sums.size() == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

	initial begin
		#20_000_000;
		$display("Timed out waiting for results");
		$display("Mismatches found");
		$finish;
	end

endmodule

// File: filelist.f
rtl/fma64_pkg.sv
rtl/fma64_chunk_lzc.sv
rtl/fused_multiply_add_binary64_core.sv
tb/tb_fused_multiply_add_binary64_core.sv
